FILE: design/csa_pkg.sv
`timescale 1ns / 1ps
package csa_pkg;

    // default datapath width and fixed port width of the operand and result fields
    localparam int DATA_WIDTH_DEF = 64;
    localparam int FIELD_W        = 64;
    localparam int FUNC_W         = 3;

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD = 3'd0,
        FN_SUB = 3'd1,
        FN_MUL = 3'd2,
        FN_DIV = 3'd3,
        FN_MOD = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OVER  = 2'd1,
        ST_UNDER = 2'd2,
        ST_DIVZ  = 2'd3
    } status_t;

    // control that rides along with each word through the cell chain
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              na;
        logic              nb;
        status_t           st;
    } ctl_t;

endpackage

FILE: design/csa_cell.sv
`timescale 1ns / 1ps
module csa_cell
    import csa_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  ctl_t                      in_ctl,
    input  logic [DATA_WIDTH-1:0]     in_ma,
    input  logic [DATA_WIDTH-1:0]     in_mb,
    input  logic [DATA_WIDTH-1:0]     in_work,
    input  logic [DATA_WIDTH-1:0]     in_mplr,
    input  logic [DATA_WIDTH:0]       in_rem,
    input  logic [2*DATA_WIDTH-1:0]   in_acc,
    input  logic [DATA_WIDTH-1:0]     in_aux,
    output logic                      out_valid,
    input  logic                      out_ready,
    output ctl_t                      out_ctl,
    output logic [DATA_WIDTH-1:0]     out_ma,
    output logic [DATA_WIDTH-1:0]     out_mb,
    output logic [DATA_WIDTH-1:0]     out_work,
    output logic [DATA_WIDTH-1:0]     out_mplr,
    output logic [DATA_WIDTH:0]       out_rem,
    output logic [2*DATA_WIDTH-1:0]   out_acc,
    output logic [DATA_WIDTH-1:0]     out_aux
);

    localparam int W = DATA_WIDTH;

    logic                valid_reg;
    ctl_t                ctl_reg;
    logic [W-1:0]        ma_reg, mb_reg, work_reg, mplr_reg, aux_reg;
    logic [W:0]          rem_reg;
    logic [2*W-1:0]      acc_reg;

    logic [W:0]          rem_sh;
    logic                ge;
    logic [W:0]          rem_next;
    logic [W-1:0]        work_next, mplr_next;
    logic [2*W-1:0]      acc_next;

    assign in_ready = !valid_reg || out_ready;

    // one restoring divide step on the remainder
    always_comb begin
        rem_sh    = {in_rem[W-1:0], in_work[W-1]};
        ge        = rem_sh >= {1'b0, in_mb};
        rem_next  = ge ? (rem_sh - {1'b0, in_mb}) : rem_sh;
        work_next = {in_work[W-2:0], ge};
    end

    // one shift-add multiply step, multiplier bits msb first
    always_comb begin
        acc_next  = {in_acc[2*W-2:0], 1'b0}
                  + (in_mplr[W-1] ? {{W{1'b0}}, in_ma} : {(2*W){1'b0}});
        mplr_next = {in_mplr[W-2:0], 1'b0};
    end

    // stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            ctl_reg  <= in_ctl;
            ma_reg   <= in_ma;
            mb_reg   <= in_mb;
            aux_reg  <= in_aux;
            work_reg <= work_next;
            rem_reg  <= rem_next;
            acc_reg  <= acc_next;
            mplr_reg <= mplr_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_ma    = ma_reg;
    assign out_mb    = mb_reg;
    assign out_work  = work_reg;
    assign out_mplr  = mplr_reg;
    assign out_rem   = rem_reg;
    assign out_acc   = acc_reg;
    assign out_aux   = aux_reg;

endmodule

FILE: design/checked_signed_alu.sv
`timescale 1ns / 1ps
// path: decode register, one cell per operand bit, output register
// one word per cycle if not stalled; each cell retires one quotient and one multiplier bit
// every cell and the output register hold their own valid bit, so bubbles close up on a stall
// reset: synchronous active-low aresetn clears all valid bits; payload registers are not reset
module checked_signed_alu
    import csa_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [FUNC_W-1:0]  s_func,
    input  logic [FIELD_W-1:0] s_operand_a,
    input  logic [FIELD_W-1:0] s_operand_b,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [FIELD_W-1:0] m_result_value,
    output logic [1:0]         m_status_code
);

    localparam int W = DATA_WIDTH;
    localparam logic [W-1:0] SIGN_BIT = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MAX_POS  = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] ONE      = {{(W-1){1'b0}}, 1'b1};

    // decode stage
    logic [W-1:0] ua, ub, ma_d, mb_d;
    logic [W:0]   s_ext;
    ctl_t         ctl_d;

    always_comb begin
        ua   = s_operand_a[W-1:0];
        ub   = s_operand_b[W-1:0];
        ma_d = ua[W-1] ? (~ua + ONE) : ua;
        mb_d = ub[W-1] ? (~ub + ONE) : ub;
        if (s_func == FN_SUB) begin
            s_ext = {ua[W-1], ua} - {ub[W-1], ub};
        end else begin
            s_ext = {ua[W-1], ua} + {ub[W-1], ub};
        end
        ctl_d.func = s_func;
        ctl_d.na   = ua[W-1];
        ctl_d.nb   = ub[W-1];
        if (s_ext[W] != s_ext[W-1]) begin
            ctl_d.st = s_ext[W] ? ST_UNDER : ST_OVER;
        end else begin
            ctl_d.st = ST_OK;
        end
    end

    logic         dec_valid_reg;
    ctl_t         dec_ctl_reg;
    logic [W-1:0] dec_ma_reg, dec_mb_reg, dec_aux_reg;

    // chain links, index 0 is the decode register
    logic               c_valid [0:W];
    logic               c_ready [0:W];
    ctl_t               c_ctl   [0:W];
    logic [W-1:0]       c_ma    [0:W];
    logic [W-1:0]       c_mb    [0:W];
    logic [W-1:0]       c_work  [0:W];
    logic [W-1:0]       c_mplr  [0:W];
    logic [W:0]         c_rem   [0:W];
    logic [2*W-1:0]     c_acc   [0:W];
    logic [W-1:0]       c_aux   [0:W];

    assign s_ready = !dec_valid_reg || c_ready[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dec_valid_reg <= 1'b0;
        end else if (s_ready) begin
            dec_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            dec_ctl_reg <= ctl_d;
            dec_ma_reg  <= ma_d;
            dec_mb_reg  <= mb_d;
            dec_aux_reg <= s_ext[W-1:0];
        end
    end

    assign c_valid[0] = dec_valid_reg;
    assign c_ctl[0]   = dec_ctl_reg;
    assign c_ma[0]    = dec_ma_reg;
    assign c_mb[0]    = dec_mb_reg;
    assign c_work[0]  = dec_ma_reg;
    assign c_mplr[0]  = dec_mb_reg;
    assign c_rem[0]   = '0;
    assign c_acc[0]   = '0;
    assign c_aux[0]   = dec_aux_reg;

    // row of divide / multiply cells
    for (genvar i = 0; i < W; i++) begin : g_cell
        csa_cell #(.DATA_WIDTH(W)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (c_valid[i]),
            .in_ready  (c_ready[i]),
            .in_ctl    (c_ctl[i]),
            .in_ma     (c_ma[i]),
            .in_mb     (c_mb[i]),
            .in_work   (c_work[i]),
            .in_mplr   (c_mplr[i]),
            .in_rem    (c_rem[i]),
            .in_acc    (c_acc[i]),
            .in_aux    (c_aux[i]),
            .out_valid (c_valid[i+1]),
            .out_ready (c_ready[i+1]),
            .out_ctl   (c_ctl[i+1]),
            .out_ma    (c_ma[i+1]),
            .out_mb    (c_mb[i+1]),
            .out_work  (c_work[i+1]),
            .out_mplr  (c_mplr[i+1]),
            .out_rem   (c_rem[i+1]),
            .out_acc   (c_acc[i+1]),
            .out_aux   (c_aux[i+1])
        );
    end

    // finishing logic on the chain tail
    ctl_t           t_ctl;
    logic [W-1:0]   t_ma, t_mb, t_q, t_r;
    logic [2*W-1:0] t_p, lim;
    logic [W:0]     t_sum;
    logic           t_neg;
    logic [W-1:0]   val;
    status_t        st;

    always_comb begin
        t_ctl = c_ctl[W];
        t_ma  = c_ma[W];
        t_mb  = c_mb[W];
        t_q   = c_work[W];
        t_r   = c_rem[W][W-1:0];
        t_p   = c_acc[W];
        t_neg = t_ctl.na ^ t_ctl.nb;
        lim   = {{W{1'b0}}, (t_neg ? SIGN_BIT : MAX_POS)};
        t_sum = {1'b0, t_r} + {1'b0, t_mb};
        val   = '0;
        st    = ST_OK;
        case (t_ctl.func)
            FN_ADD, FN_SUB: begin
                st  = t_ctl.st;
                val = c_aux[W];
            end
            FN_MUL: begin
                if (t_p > lim) begin
                    st = t_neg ? ST_UNDER : ST_OVER;
                end else begin
                    val = t_neg ? (~t_p[W-1:0] + ONE) : t_p[W-1:0];
                end
            end
            FN_DIV: begin
                if (t_mb == '0) begin
                    st = ST_DIVZ;
                end else if (t_ctl.na && t_ctl.nb && t_ma == SIGN_BIT && t_mb == ONE) begin
                    st = ST_OVER;
                end else begin
                    val = t_neg ? (~t_q + ONE) : t_q;
                end
            end
            FN_MOD: begin
                if (t_mb == '0) begin
                    st = ST_DIVZ;
                end else if (t_ctl.na && t_r != '0) begin
                    if (!t_ctl.nb) begin
                        val = t_mb - t_r;
                    end else if (t_sum > {1'b0, SIGN_BIT}) begin
                        st = ST_UNDER;
                    end else begin
                        val = ~t_sum[W-1:0] + ONE;
                    end
                end else begin
                    val = t_r;
                end
            end
            default: begin
                val = '0;
            end
        endcase
        if (st != ST_OK) begin
            val = '0;
        end
    end

    // output register
    logic               out_valid_reg;
    logic [FIELD_W-1:0] out_val_reg;
    status_t            out_st_reg;

    assign c_ready[W] = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (c_ready[W]) begin
            out_valid_reg <= c_valid[W];
        end
    end

    always_ff @(posedge aclk) begin
        if (c_ready[W] && c_valid[W]) begin
            out_val_reg <= FIELD_W'($signed(val));
            out_st_reg  <= st;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_result_value = out_val_reg;
    assign m_status_code  = out_st_reg;

endmodule
